/* sv/vtsd_pkg.sv */
// ----------------------------------------------------------------------------
// Value table package
// Shared constants, request and result item types, and the control and status
// bundles between the sequencer and the scan unit.
// ----------------------------------------------------------------------------
package vtsd_pkg;

  localparam int CAPACITY    = 16;
  localparam int VAL_W       = 31;
  localparam int FIELD_CNT_W = 5;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    KIND_CLEAR     = 3'd0,
    KIND_APPEND    = 3'd1,
    KIND_SEARCH    = 3'd2,
    KIND_COUNT     = 3'd3,
    KIND_DEL_FIRST = 3'd4,
    KIND_DEL_ALL   = 3'd5,
    KIND_UPDATE    = 3'd6,
    KIND_EXTREMES  = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_REJECTED  = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    kind_e            kind;
    logic [VAL_W-1:0] key_value;
    logic [VAL_W-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    status_e                status;
    logic [FIELD_CNT_W-1:0] position;
    logic [FIELD_CNT_W-1:0] match_count;
    logic [VAL_W-1:0]       max_value;
    logic [VAL_W-1:0]       min_value;
    logic [FIELD_CNT_W-1:0] fill_count;
    logic [FIELD_CNT_W-1:0] empty_count;
    logic                   is_empty;
    logic                   is_full;
  } out_item_t;

  // Sequencer to scan unit
  typedef struct packed {
    logic             init;
    logic             eval;
    logic [IDX_W-1:0] idx;
    kind_e            kind;
    logic [VAL_W-1:0] key;
    logic [VAL_W-1:0] new_value;
  } scan_ctrl_t;

  // Scan unit to sequencer and table write port
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] first_idx;
    logic [CNT_W-1:0] match_cnt;
    logic [CNT_W-1:0] kept;
    logic [VAL_W-1:0] max_value;
    logic [VAL_W-1:0] min_value;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
  } scan_stat_t;

endpackage

/* sv/vtsd_mem.sv */
// ----------------------------------------------------------------------------
// Value table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vtsd_mem (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [vtsd_pkg::IDX_W-1:0] wr_addr_i,
  input  logic [vtsd_pkg::VAL_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [vtsd_pkg::IDX_W-1:0] rd_addr_i,
  output logic [vtsd_pkg::VAL_W-1:0] rd_data_o
);
  import vtsd_pkg::*;

  logic [VAL_W-1:0] mem_q [CAPACITY];
  logic [VAL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/vtsd_scan.sv */
// ----------------------------------------------------------------------------
// Value table scan unit
// Compares one table entry per cycle against the key, keeps the match
// bookkeeping and running extremes, and drives compaction and update writes.
// ----------------------------------------------------------------------------
module vtsd_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vtsd_pkg::scan_ctrl_t       ctrl_i,
  input  logic [vtsd_pkg::VAL_W-1:0] rd_data_i,
  output vtsd_pkg::scan_stat_t       stat_o
);
  import vtsd_pkg::*;

  logic             found_q;
  logic [IDX_W-1:0] first_idx_q;
  logic [CNT_W-1:0] match_q;
  logic [CNT_W-1:0] kept_q;
  logic [VAL_W-1:0] max_q;
  logic [VAL_W-1:0] min_q;
  logic             hit;
  logic             drop;
  logic             is_del;

  always_comb begin
    hit    = ctrl_i.eval && (rd_data_i == ctrl_i.key);
    is_del = (ctrl_i.kind == KIND_DEL_FIRST) || (ctrl_i.kind == KIND_DEL_ALL);
    drop   = hit && ((ctrl_i.kind == KIND_DEL_ALL) ||
                     ((ctrl_i.kind == KIND_DEL_FIRST) && !found_q));

    stat_o.found     = found_q;
    stat_o.first_idx = first_idx_q;
    stat_o.match_cnt = match_q;
    stat_o.kept      = kept_q;
    stat_o.max_value = max_q;
    stat_o.min_value = min_q;
    stat_o.wr_en     = 1'b0;
    stat_o.wr_addr   = kept_q[IDX_W-1:0];
    stat_o.wr_data   = rd_data_i;
    if (is_del) begin
      // move each kept entry down to the write pointer
      stat_o.wr_en = ctrl_i.eval && !drop;
    end else if (ctrl_i.kind == KIND_UPDATE) begin
      stat_o.wr_en   = hit && !found_q;
      stat_o.wr_addr = ctrl_i.idx;
      stat_o.wr_data = ctrl_i.new_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      first_idx_q <= '0;
      match_q     <= '0;
      kept_q      <= '0;
      max_q       <= '0;
      min_q       <= '0;
    end else if (ctrl_i.init) begin
      found_q <= 1'b0;
      match_q <= '0;
      kept_q  <= '0;
    end else if (ctrl_i.eval) begin
      if (hit && !found_q) begin
        found_q     <= 1'b1;
        first_idx_q <= ctrl_i.idx;
      end
      if (hit) begin
        match_q <= match_q + CNT_W'(1);
      end
      if (!drop) begin
        kept_q <= kept_q + CNT_W'(1);
      end
      if (ctrl_i.idx == '0) begin
        max_q <= rd_data_i;
        min_q <= rd_data_i;
      end else begin
        if (rd_data_i > max_q) begin
          max_q <= rd_data_i;
        end
        if (rd_data_i < min_q) begin
          min_q <= rd_data_i;
        end
      end
    end
  end

endmodule

/* sv/value_table_search_delete.sv */
// ----------------------------------------------------------------------------
// Value table with search and delete
// Packed unsorted list of values with a fill count, served one request at a
// time.
// ----------------------------------------------------------------------------
// Usage:
//   Request items enter on in_item_i under in_valid_i / in_stall_o; each
//   request gives exactly one result item on out_item_o under out_valid_o /
//   out_stall_i.
//   Clear, append, and any request on an empty table finish at once: the
//   result is registered at the accepting edge.
//   Search, count, delete first, delete all, update first and extremes walk
//   the filled entries through one comparator, one entry per cycle off the
//   table's single read port: the read data is registered, the scan unit
//   folds it in, and the result is registered once the walk ends and the
//   output register is free; the next request is accepted only after that.
//   A result waits in the output register while the receiver stalls; a
//   walking request may be accepted meanwhile, but one that would finish at
//   once is held off until the result is taken.
//   Reset empties the table (fill count zero) and clears the output valid.
// ----------------------------------------------------------------------------
module value_table_search_delete (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vtsd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vtsd_pkg::out_item_t out_item_o
);
  import vtsd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             pend_q;
  logic [IDX_W-1:0] ev_idx_q;
  in_item_t         req_q;
  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             out_free;
  logic             immediate;
  logic             accept;
  logic             issue;
  logic             app_wr;
  logic             load;
  scan_ctrl_t       ctrl;
  scan_stat_t       stat;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  logic [VAL_W-1:0] mem_wr_data;
  logic [VAL_W-1:0] rd_data;
  logic [CNT_W-1:0] scan_used;

  function automatic out_item_t make_result(status_e st, logic [CNT_W-1:0] pos,
                                            logic [CNT_W-1:0] cnt,
                                            logic [VAL_W-1:0] mx,
                                            logic [VAL_W-1:0] mn,
                                            logic [CNT_W-1:0] used);
    out_item_t r;
    r.status      = st;
    r.position    = FIELD_CNT_W'(pos);
    r.match_count = FIELD_CNT_W'(cnt);
    r.max_value   = mx;
    r.min_value   = mn;
    r.fill_count  = FIELD_CNT_W'(used);
    r.empty_count = FIELD_CNT_W'(CNT_W'(CAPACITY) - used);
    r.is_empty    = (used == '0);
    r.is_full     = (used == CNT_W'(CAPACITY));
    return r;
  endfunction

  vtsd_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (issue),
    .rd_addr_i (rd_idx_q[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  vtsd_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .rd_data_i (rd_data),
    .stat_o    (stat)
  );

  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    immediate  = (in_item_i.kind == KIND_CLEAR) || (in_item_i.kind == KIND_APPEND) ||
                 (used_q == '0);
    in_stall_o = !((state_q == S_IDLE) && (out_free || !immediate));
    accept     = in_valid_i && !in_stall_o;
    issue      = (state_q == S_SCAN) && (rd_idx_q < used_q);

    ctrl.init      = accept;
    ctrl.eval      = pend_q;
    ctrl.idx       = ev_idx_q;
    ctrl.kind      = req_q.kind;
    ctrl.key       = req_q.key_value;
    ctrl.new_value = req_q.new_value;

    app_wr = accept && (in_item_i.kind == KIND_APPEND) && (in_item_i.key_value != '0) &&
             (used_q != CNT_W'(CAPACITY));

    mem_wr_en   = app_wr || stat.wr_en;
    mem_wr_addr = app_wr ? used_q[IDX_W-1:0] : stat.wr_addr;
    mem_wr_data = app_wr ? in_item_i.key_value : stat.wr_data;

    state_d  = state_q;
    used_d   = used_q;
    rd_idx_d = rd_idx_q;
    out_d    = out_q;
    load     = 1'b0;

    scan_used = ((req_q.kind == KIND_DEL_FIRST) || (req_q.kind == KIND_DEL_ALL)) ?
                stat.kept : used_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (in_item_i.kind == KIND_CLEAR) begin
            load   = 1'b1;
            used_d = '0;
            out_d  = make_result(ST_OK, '0, '0, '0, '0, '0);
          end else if (in_item_i.kind == KIND_APPEND) begin
            load = 1'b1;
            if (app_wr) begin
              used_d = used_q + CNT_W'(1);
              out_d  = make_result(ST_OK, '0, '0, '0, '0, used_q + CNT_W'(1));
            end else begin
              out_d  = make_result(ST_REJECTED, '0, '0, '0, '0, used_q);
            end
          end else if (used_q == '0) begin
            load  = 1'b1;
            out_d = make_result(ST_EMPTY, '0, '0, '0, '0, used_q);
          end else begin
            rd_idx_d = '0;
            state_d  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end else if (!pend_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load    = 1'b1;
          used_d  = scan_used;
          state_d = S_IDLE;
          unique case (req_q.kind)
            KIND_SEARCH: begin
              out_d = make_result(stat.found ? ST_OK : ST_NOT_FOUND,
                                  stat.found ? CNT_W'(stat.first_idx) + CNT_W'(1) : '0,
                                  '0, '0, '0, scan_used);
            end
            KIND_COUNT, KIND_DEL_ALL: begin
              out_d = make_result(stat.found ? ST_OK : ST_NOT_FOUND, '0, stat.match_cnt,
                                  '0, '0, scan_used);
            end
            KIND_DEL_FIRST: begin
              out_d = make_result(stat.found ? ST_OK : ST_NOT_FOUND, '0,
                                  stat.found ? CNT_W'(1) : '0, '0, '0, scan_used);
            end
            KIND_EXTREMES: begin
              out_d = make_result(ST_OK, '0, '0, stat.max_value, stat.min_value,
                                  scan_used);
            end
            default: begin
              // update first; clear and append never reach here
              out_d = make_result(stat.found ? ST_OK : ST_NOT_FOUND, '0, '0, '0, '0,
                                  scan_used);
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      ev_idx_q    <= '0;
      req_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= issue;
      out_valid_q <= out_valid_d;
      if (issue) begin
        ev_idx_q <= rd_idx_q[IDX_W-1:0];
      end
      if (accept) begin
        req_q <= in_item_i;
      end
      if (load) begin
        out_q <= out_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (rd_idx_q <= used_q))
    else $error("scan read index past fill count");

  a_kept_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (stat.kept <= rd_idx_q))
    else $error("compaction pointer ahead of read pointer");

  a_scan_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (used_q <= $past(used_q)))
    else $error("scan request grew the table");

endmodule

/* verif/tb_value_table_search_delete.sv */
// ----------------------------------------------------------------------------
// Value table search/delete testbench
// Sends request items under random bursts and gaps while the result side
// stalls on its own random pattern. A shadow copy of the table predicts every
// result at acceptance, and each result taken is compared field by field in
// order. Covers the empty, full and no-match cases and every request kind.
// ----------------------------------------------------------------------------
module tb_value_table_search_delete;
  import vtsd_pkg::*;

  localparam int ITEM_TARGET = 1100;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_PRINTS  = 50;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  // Shadow table, updated in acceptance order
  logic [VAL_W-1:0] tbl_vals [CAPACITY];
  int               tbl_fill = 0;
  out_item_t        pending_results [$];

  int err_cnt     = 0;
  int sent_cnt    = 0;
  int checked_cnt = 0;
  int burst_left  = 1;
  int cycle_cnt   = 0;

  value_table_search_delete u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Apply one request to the shadow table and return the result it gives
  function automatic out_item_t compute_table_result(input in_item_t req);
    out_item_t        res;
    int               i;
    int               hit;
    int               n;
    int               w;
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] lo;
    res = '0;
    res.status = ST_OK;
    hit = -1;
    n = 0;
    for (i = 0; i < tbl_fill; i++) begin
      if (hit < 0 && tbl_vals[i] == req.key_value) hit = i;
    end
    case (req.kind)
      KIND_CLEAR: tbl_fill = 0;
      KIND_APPEND: begin
        if (req.key_value == '0 || tbl_fill >= CAPACITY) begin
          res.status = ST_REJECTED;
        end else begin
          tbl_vals[tbl_fill] = req.key_value;
          tbl_fill++;
        end
      end
      default: begin
        if (tbl_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          case (req.kind)
            KIND_SEARCH: begin
              if (hit < 0) res.status = ST_NOT_FOUND;
              else res.position = FIELD_CNT_W'(hit + 1);
            end
            KIND_COUNT: begin
              for (i = 0; i < tbl_fill; i++) begin
                if (tbl_vals[i] == req.key_value) n++;
              end
              if (n == 0) res.status = ST_NOT_FOUND;
              res.match_count = FIELD_CNT_W'(n);
            end
            KIND_DEL_FIRST: begin
              if (hit < 0) begin
                res.status = ST_NOT_FOUND;
              end else begin
                // close the gap
                for (i = hit; i < tbl_fill - 1; i++) tbl_vals[i] = tbl_vals[i + 1];
                tbl_fill--;
                res.match_count = FIELD_CNT_W'(1);
              end
            end
            KIND_DEL_ALL: begin
              w = 0;
              for (i = 0; i < tbl_fill; i++) begin
                if (tbl_vals[i] == req.key_value) begin
                  n++;
                end else begin
                  tbl_vals[w] = tbl_vals[i];
                  w++;
                end
              end
              tbl_fill = w;
              if (n == 0) res.status = ST_NOT_FOUND;
              res.match_count = FIELD_CNT_W'(n);
            end
            KIND_UPDATE: begin
              if (hit < 0) res.status = ST_NOT_FOUND;
              else tbl_vals[hit] = req.new_value;
            end
            KIND_EXTREMES: begin
              hi = tbl_vals[0];
              lo = tbl_vals[0];
              for (i = 1; i < tbl_fill; i++) begin
                if (tbl_vals[i] > hi) hi = tbl_vals[i];
                if (tbl_vals[i] < lo) lo = tbl_vals[i];
              end
              res.max_value = hi;
              res.min_value = lo;
            end
            default: ;
          endcase
        end
      end
    endcase
    res.fill_count  = FIELD_CNT_W'(tbl_fill);
    res.empty_count = FIELD_CNT_W'(CAPACITY - tbl_fill);
    res.is_empty    = (tbl_fill == 0);
    res.is_full     = (tbl_fill == CAPACITY);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("mismatch on result %0d, %s: got %0h, want %0h", checked_cnt, what, got, want);
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.position !== want.position)
      report_mismatch("position", 32'(got.position), 32'(want.position));
    if (got.match_count !== want.match_count)
      report_mismatch("match_count", 32'(got.match_count), 32'(want.match_count));
    if (got.max_value !== want.max_value)
      report_mismatch("max_value", 32'(got.max_value), 32'(want.max_value));
    if (got.min_value !== want.min_value)
      report_mismatch("min_value", 32'(got.min_value), 32'(want.min_value));
    if (got.fill_count !== want.fill_count)
      report_mismatch("fill_count", 32'(got.fill_count), 32'(want.fill_count));
    if (got.empty_count !== want.empty_count)
      report_mismatch("empty_count", 32'(got.empty_count), 32'(want.empty_count));
    if (got.is_empty !== want.is_empty)
      report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
    if (got.is_full !== want.is_full)
      report_mismatch("is_full", 32'(got.is_full), 32'(want.is_full));
    checked_cnt++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("item with none pending", 32'd0, 32'd0);
      end else begin
        check_result(out_item_o, pending_results.pop_front());
      end
    end
  end

  // Result side: stall in stretches, each with a mode of its own
  initial begin
    int mode;
    int span;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  // Hold the item until accepted, then predict; drop valid only at a burst end
  task automatic send_req(input kind_e kind, input logic [VAL_W-1:0] key,
                          input logic [VAL_W-1:0] nval);
    in_item_t req;
    req.kind      = kind;
    req.key_value = key;
    req.new_value = nval;
    in_item_i  <= req;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(compute_table_result(req));
    sent_cnt++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: v = VAL_W'($urandom_range(1, 6));
      4: v = '1;
      5: v = VAL_W'($urandom_range(0, 1));
      default: v = VAL_W'($urandom);
    endcase
    return v;
  endfunction

  // Mostly a key that is stored, so matches and deletions happen
  function automatic logic [VAL_W-1:0] pick_key();
    if (tbl_fill > 0 && $urandom_range(0, 3) != 0)
      return tbl_vals[IDX_W'($urandom_range(0, tbl_fill - 1))];
    return pick_value();
  endfunction

  function automatic kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return KIND_CLEAR;
    if (r < 28) return KIND_APPEND;
    if (r < 43) return KIND_SEARCH;
    if (r < 55) return KIND_COUNT;
    if (r < 70) return KIND_DEL_FIRST;
    if (r < 80) return KIND_DEL_ALL;
    if (r < 92) return KIND_UPDATE;
    return KIND_EXTREMES;
  endfunction

  task automatic test_directed_corners();
    send_req(KIND_SEARCH, 31'd5, '0);
    send_req(KIND_COUNT, 31'd5, '0);
    send_req(KIND_DEL_FIRST, 31'd5, '0);
    send_req(KIND_DEL_ALL, 31'd5, '0);
    send_req(KIND_UPDATE, 31'd5, '1);
    send_req(KIND_EXTREMES, '0, '0);
    send_req(KIND_APPEND, '0, '0);
    send_req(KIND_APPEND, '1, '0);
    send_req(KIND_APPEND, 31'd1, '0);
    send_req(KIND_APPEND, 31'd1, '0);
    send_req(KIND_EXTREMES, '1, '1);
    send_req(KIND_SEARCH, 31'd1, '0);
    send_req(KIND_SEARCH, 31'd2, '0);
    send_req(KIND_COUNT, 31'd1, '0);
    // zero is a legal replacement value
    send_req(KIND_UPDATE, 31'd1, '0);
    send_req(KIND_SEARCH, '0, '0);
    send_req(KIND_DEL_FIRST, '1, '0);
    send_req(KIND_DEL_ALL, 31'd9, '0);
    send_req(KIND_EXTREMES, '0, '0);
    send_req(KIND_DEL_ALL, 31'd1, '0);
    send_req(KIND_CLEAR, '1, '1);
    send_req(KIND_EXTREMES, '0, '0);
  endtask

  task automatic test_full_table();
    int round;
    int k;
    for (round = 0; round < 4; round++) begin
      send_req(KIND_CLEAR, pick_value(), pick_value());
      for (k = 0; k < CAPACITY; k++) begin
        if ($urandom_range(0, 3) == 0) send_req(KIND_APPEND, VAL_W'($urandom | 1), pick_value());
        else send_req(KIND_APPEND, VAL_W'($urandom_range(1, 3)), pick_value());
      end
      send_req(KIND_APPEND, pick_value(), pick_value());
      send_req(KIND_EXTREMES, pick_value(), pick_value());
      send_req(KIND_SEARCH, tbl_vals[CAPACITY - 1], '0);
      send_req(KIND_COUNT, tbl_vals[0], '0);
      send_req(KIND_UPDATE, tbl_vals[CAPACITY - 1], pick_value());
      send_req(KIND_DEL_FIRST, tbl_vals[CAPACITY - 1], '0);
      send_req(KIND_APPEND, pick_value(), '0);
      send_req(KIND_DEL_ALL, tbl_vals[0], '0);
      send_req(KIND_EXTREMES, '0, '0);
    end
  endtask

  // Fill to a random level, then run a random mix of requests on it
  task automatic test_random_mix();
    int target;
    int ops;
    while (sent_cnt < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) send_req(KIND_CLEAR, pick_value(), pick_value());
      target = $urandom_range(0, CAPACITY);
      while (tbl_fill < target) send_req(KIND_APPEND, pick_value(), pick_value());
      ops = $urandom_range(4, 24);
      repeat (ops) send_req(pick_kind(), pick_key(), pick_value());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    wait_results_drained();
    test_full_table();
    wait_results_drained();
    test_random_mix();
    wait_results_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
